// ===== hw/rtl/tsp_pkg.sv =====
// Shared types and constants of the tone sequence player.
package tsp_pkg;

  // Request kinds
  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_PLAY  = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  // Loudness levels of a melody
  localparam logic [1:0] LVL_NORMAL = 2'd0;
  localparam logic [1:0] LVL_QUIET  = 2'd1;
  localparam logic [1:0] LVL_FULL   = 2'd2;

  // Configuration register indexes
  localparam logic CFG_VOLUME     = 1'b0;
  localparam logic CFG_ACTIVE_LOW = 1'b1;

  localparam logic [6:0]  VOLUME_RST    = 7'd100;
  localparam logic [6:0]  PCT_FULL      = 7'd100;
  localparam logic [6:0]  PCT_QUIET_MIN = 7'd3;
  localparam logic [15:0] MS_MAX        = 16'hFFFF;

  // One input request
  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  tone_index;
    logic [15:0] tone_hz;
    logic [15:0] tone_ms;
    logic [7:0]  play_start;
    logic [7:0]  play_count;
    logic [1:0]  play_level;
    logic        urgent;
  } tsp_item_t;

  // One tone store entry
  typedef struct packed {
    logic [15:0] hz;
    logic [15:0] ms;
  } tsp_tone_t;

endpackage

// ===== hw/rtl/tsp_in_if.sv =====
// Request channel of the tone sequence player.
interface tsp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  tone_index;
  logic [15:0] tone_hz;
  logic [15:0] tone_ms;
  logic [7:0]  play_start;
  logic [7:0]  play_count;
  logic [1:0]  play_level;
  logic        urgent;

  modport source (
    output valid, action, tone_index, tone_hz, tone_ms,
    output play_start, play_count, play_level, urgent,
    input  ready
  );
  modport sink (
    input  valid, action, tone_index, tone_hz, tone_ms,
    input  play_start, play_count, play_level, urgent,
    output ready
  );
endinterface

// ===== hw/rtl/tsp_out_if.sv =====
// Result channel of the tone sequence player.
interface tsp_out_if #(
  parameter int DUTY_BITS = 10
);
  logic                 valid;
  logic                 ready;
  logic [15:0]          freq_hz;
  logic [DUTY_BITS-1:0] duty;
  logic                 playing;
  logic [2:0]           queued;

  modport source (
    output valid, freq_hz, duty, playing, queued,
    input  ready
  );
  modport sink (
    input  valid, freq_hz, duty, playing, queued,
    output ready
  );
endinterface

// ===== hw/rtl/tsp_tone_mem.sv =====
// Tone store: one write port, one registered read port with write bypass.
module tsp_tone_mem #(
  parameter int TONE_DEPTH = 256,
  localparam int TA = $clog2(TONE_DEPTH)
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [TA-1:0]       wr_addr,
  input  tsp_pkg::tsp_tone_t  wr_data,
  input  logic [TA-1:0]       rd_addr,
  output tsp_pkg::tsp_tone_t  rd_data
);
  import tsp_pkg::*;

  tsp_tone_t mem_r [TONE_DEPTH];
  tsp_tone_t rd_data_r;

  // Store written entries
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Read every cycle; forward a write to the same entry
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/tsp_ctrl.sv =====
// Melody queue and step sequencer of the tone sequence player.
module tsp_ctrl #(
  parameter int QUEUE_DEPTH = 4,
  parameter int TONE_DEPTH  = 256,
  localparam int TA = $clog2(TONE_DEPTH),
  localparam int QA = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int FW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                proc,
  input  tsp_pkg::tsp_item_t  item,
  input  tsp_pkg::tsp_tone_t  cur_tone,
  output logic                wr_en,
  output logic [TA-1:0]       wr_addr,
  output tsp_pkg::tsp_tone_t  wr_tone,
  output logic [TA-1:0]       rd_addr,
  output logic                busy,
  output logic [1:0]          level,
  output logic [FW-1:0]       fill
);
  import tsp_pkg::*;

  // Entry numbers taken modulo the store depth
  logic [TA-1:0] mod_tab [256];
  for (genvar g = 0; g < 256; g++) begin : g_mod
    assign mod_tab[g] = TA'(g % TONE_DEPTH);
  end

  logic          busy_r, busy_nxt;
  logic [QA-1:0] head_r, head_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [7:0]    len_r, len_nxt;
  logic [1:0]    level_r, level_nxt;
  logic [7:0]    step_r, step_nxt;
  logic [15:0]   el_r, el_nxt;
  logic [TA-1:0] ptr_r, ptr_nxt;

  logic [TA-1:0] qs_r [QUEUE_DEPTH];
  logic [7:0]    ql_r [QUEUE_DEPTH];
  logic [1:0]    qv_r [QUEUE_DEPTH];

  logic          play_ok;
  logic [FW-1:0] fill_t;
  logic [QA:0]   slot_sum;
  logic [QA-1:0] slot;
  logic          enq;
  logic          fwd;
  logic          do_begin;
  logic [TA-1:0] hd_start;
  logic [7:0]    hd_len;
  logic [1:0]    hd_level;
  logic [QA-1:0] head_inc;
  logic [TA-1:0] ptr_inc;
  logic [7:0]    step_inc;
  logic [15:0]   el_inc;

  // Decode the request
  assign play_ok = proc && (item.action == ACT_PLAY) && (item.play_count != 8'd0);
  assign fill_t  = item.urgent ? '0 : fill_r;
  assign wr_en   = proc && (item.action == ACT_WRITE);
  assign wr_addr = mod_tab[item.tone_index];
  assign wr_tone = '{hz: item.tone_hz, ms: item.tone_ms};

  // Tail slot of the queue
  assign slot_sum = (QA+1)'(head_r) + (QA+1)'(fill_t);
  always_comb begin
    if (slot_sum >= (QA+1)'(QUEUE_DEPTH)) begin
      slot = QA'(slot_sum - (QA+1)'(QUEUE_DEPTH));
    end else begin
      slot = QA'(slot_sum);
    end
  end

  // Head entry; take the new melody when it lands on an empty queue
  assign fwd      = play_ok && (fill_t == '0);
  assign hd_start = fwd ? mod_tab[item.play_start] : qs_r[head_r];
  assign hd_len   = fwd ? item.play_count : ql_r[head_r];
  assign hd_level = fwd ? item.play_level : qv_r[head_r];

  assign head_inc = (head_r == QA'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign ptr_inc  = (ptr_r == TA'(TONE_DEPTH - 1)) ? '0 : ptr_r + 1'b1;
  assign step_inc = step_r + 8'd1;
  assign el_inc   = (el_r == MS_MAX) ? el_r : el_r + 16'd1;

  // Update queue and step state for one request
  always_comb begin
    busy_nxt  = busy_r;
    head_nxt  = head_r;
    fill_nxt  = fill_r;
    len_nxt   = len_r;
    level_nxt = level_r;
    step_nxt  = step_r;
    el_nxt    = el_r;
    ptr_nxt   = ptr_r;
    enq       = 1'b0;
    do_begin  = 1'b0;
    if (proc) begin
      unique case (item.action)
        ACT_PLAY: begin
          if (item.play_count != 8'd0) begin
            if (item.urgent) begin
              fill_nxt = '0;
              busy_nxt = 1'b0;
            end
            if (fill_nxt < FW'(QUEUE_DEPTH)) begin
              enq      = 1'b1;
              fill_nxt = fill_nxt + 1'b1;
            end
            do_begin = !busy_nxt;
          end
        end
        ACT_TICK: begin
          if (busy_r) begin
            el_nxt = el_inc;
            if (el_inc >= cur_tone.ms) begin
              step_nxt = step_inc;
              el_nxt   = '0;
              if (step_inc >= len_r) begin
                do_begin = 1'b1;
              end else begin
                ptr_nxt = ptr_inc;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
    // Start the next queued melody, or go idle
    if (do_begin) begin
      if (fill_nxt == '0) begin
        busy_nxt = 1'b0;
      end else begin
        busy_nxt  = 1'b1;
        head_nxt  = head_inc;
        fill_nxt  = fill_nxt - 1'b1;
        ptr_nxt   = hd_start;
        len_nxt   = hd_len;
        level_nxt = hd_level;
        step_nxt  = '0;
        el_nxt    = '0;
      end
    end
  end

  // Hold sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      head_r  <= '0;
      fill_r  <= '0;
      len_r   <= '0;
      level_r <= '0;
      step_r  <= '0;
      el_r    <= '0;
      ptr_r   <= '0;
    end else begin
      busy_r  <= busy_nxt;
      head_r  <= head_nxt;
      fill_r  <= fill_nxt;
      len_r   <= len_nxt;
      level_r <= level_nxt;
      step_r  <= step_nxt;
      el_r    <= el_nxt;
      ptr_r   <= ptr_nxt;
    end
  end

  // Enqueue melodies
  always_ff @(posedge clk) begin
    if (enq) begin
      qs_r[slot] <= mod_tab[item.play_start];
      ql_r[slot] <= item.play_count;
      qv_r[slot] <= item.play_level;
    end
  end

  assign rd_addr = ptr_nxt;
  assign busy    = busy_r;
  assign level   = level_r;
  assign fill    = fill_r;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(QUEUE_DEPTH))
    else $error("queue fill above depth");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (fill_r == '0))
    else $error("melodies queued while idle");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (step_r < len_r))
    else $error("step past end of melody");
`endif

endmodule

// ===== hw/rtl/tsp_duty.sv =====
// Loudness and PWM duty of the sounding tone.
module tsp_duty #(
  parameter int DUTY_BITS = 10
) (
  input  logic                 busy,
  input  logic [1:0]           level,
  input  logic [6:0]           volume,
  input  logic                 active_low,
  input  logic [15:0]          tone_hz,
  output logic [15:0]          freq_hz,
  output logic [DUTY_BITS-1:0] duty
);
  import tsp_pkg::*;

  localparam logic [DUTY_BITS-1:0] DUTY_TOP = '1;

  // On time for each percentage: half scale * pct / 100
  logic [DUTY_BITS-1:0] on_tab [128];
  for (genvar g = 0; g < 128; g++) begin : g_on
    assign on_tab[g] = DUTY_BITS'((g * (1 << (DUTY_BITS - 1))) / 100);
  end

  logic [4:0]           quarter;
  logic [6:0]           pct;
  logic [DUTY_BITS-1:0] on_val;
  logic                 silent;

  // Pick the loudness percentage
  assign quarter = volume[6:2];
  always_comb begin
    case (level)
      LVL_FULL:  pct = PCT_FULL;
      LVL_QUIET: begin
        if (volume == 7'd0) begin
          pct = 7'd0;
        end else if ({2'b00, quarter} < PCT_QUIET_MIN) begin
          pct = PCT_QUIET_MIN;
        end else begin
          pct = {2'b00, quarter};
        end
      end
      LVL_NORMAL: pct = volume;
      default:    pct = volume;
    endcase
  end

  // Drive idle level when nothing sounds
  assign on_val  = on_tab[pct];
  assign silent  = !busy || (tone_hz == 16'd0) || (pct == 7'd0);
  assign freq_hz = silent ? 16'd0 : tone_hz;
  always_comb begin
    if (silent) begin
      duty = active_low ? DUTY_TOP : '0;
    end else begin
      duty = active_low ? (DUTY_TOP - on_val) : on_val;
    end
  end

endmodule

// ===== hw/rtl/tone_sequence_player.sv =====
// Tone sequence player: buzzer melody queue with PWM duty output.
// A request passes the request register, the sequencer step and the result register.
// Throughput: one request per cycle; a stalled result holds the pipe in place.
// The tone store address comes from the next sequencer entry, so the registered read matches the entry in use.
// Reset clears the queue, the sequencer and the pipe; volume 100, active_low 0.
// Tone store contents stay undefined until written.
module tone_sequence_player #(
  parameter int QUEUE_DEPTH = 4,
  parameter int TONE_DEPTH  = 256,
  parameter int DUTY_BITS   = 10
) (
  input  logic       clk,
  input  logic       rst_n,
  tsp_in_if.sink     in_if,
  tsp_out_if.source  out_if,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [6:0] cfg_wdata
);
  import tsp_pkg::*;

  localparam int TA = $clog2(TONE_DEPTH);
  localparam int FW = $clog2(QUEUE_DEPTH + 1);

  logic       volume_r;
  logic [6:0] vol_r;
  logic       active_low_r;

  logic      p_v_r;
  tsp_item_t p_item_r;
  logic      r_v_r;
  logic      o_v_r;

  logic                 o_free;
  logic                 r_free;
  logic                 r_go;
  logic                 proc;
  logic                 p_free;

  logic                 wr_en;
  logic [TA-1:0]        wr_addr;
  tsp_tone_t            wr_tone;
  logic [TA-1:0]        rd_addr;
  tsp_tone_t            tone_rd;
  logic                 busy;
  logic [1:0]           level;
  logic [FW-1:0]        fill;
  logic [FW+2:0]        fill_wide;

  logic [15:0]          freq_c;
  logic [DUTY_BITS-1:0] duty_c;
  logic [15:0]          freq_r;
  logic [DUTY_BITS-1:0] duty_r;
  logic                 playing_r;
  logic [2:0]           queued_r;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vol_r        <= VOLUME_RST;
      active_low_r <= 1'b0;
      volume_r     <= 1'b0;
    end else begin
      volume_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_VOLUME:     begin
            vol_r    <= cfg_wdata;
            volume_r <= 1'b1;
          end
          CFG_ACTIVE_LOW: active_low_r <= cfg_wdata[0];
        endcase
      end
    end
  end

  // Advance the pipe: request register, sequencer step, result register
  assign o_free = !o_v_r || out_if.ready;
  assign r_go   = r_v_r && o_free;
  assign r_free = !r_v_r || o_free;
  assign proc   = p_v_r && r_free;
  assign p_free = !p_v_r || r_free;
  assign in_if.ready = p_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
      r_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (p_free) begin
        p_v_r <= in_if.valid;
      end
      if (r_free) begin
        r_v_r <= proc;
      end
      if (o_free) begin
        o_v_r <= r_go;
      end
    end
  end

  // Capture the request payload
  always_ff @(posedge clk) begin
    if (p_free && in_if.valid) begin
      p_item_r <= '{action:     in_if.action,
                    tone_index: in_if.tone_index,
                    tone_hz:    in_if.tone_hz,
                    tone_ms:    in_if.tone_ms,
                    play_start: in_if.play_start,
                    play_count: in_if.play_count,
                    play_level: in_if.play_level,
                    urgent:     in_if.urgent};
    end
  end

  tsp_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TONE_DEPTH  (TONE_DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .proc     (proc),
    .item     (p_item_r),
    .cur_tone (tone_rd),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_tone  (wr_tone),
    .rd_addr  (rd_addr),
    .busy     (busy),
    .level    (level),
    .fill     (fill)
  );

  tsp_tone_mem #(
    .TONE_DEPTH (TONE_DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_tone),
    .rd_addr (rd_addr),
    .rd_data (tone_rd)
  );

  tsp_duty #(
    .DUTY_BITS (DUTY_BITS)
  ) u_duty (
    .busy       (busy),
    .level      (level),
    .volume     (vol_r),
    .active_low (active_low_r),
    .tone_hz    (tone_rd.hz),
    .freq_hz    (freq_c),
    .duty       (duty_c)
  );

  // Register the result
  assign fill_wide = {3'b000, fill};
  always_ff @(posedge clk) begin
    if (r_go) begin
      freq_r    <= freq_c;
      duty_r    <= duty_c;
      playing_r <= busy;
      queued_r  <= fill_wide[2:0];
    end
  end

  assign out_if.valid   = o_v_r;
  assign out_if.freq_hz = freq_r;
  assign out_if.duty    = duty_r;
  assign out_if.playing = playing_r;
  assign out_if.queued  = queued_r;

`ifndef SYNTHESIS
  a_step_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    proc |=> r_v_r)
    else $error("processed request lost before result stage");

  a_read_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (r_v_r && !o_free) |=> (tone_rd === $past(tone_rd)))
    else $error("tone read changed while result stalled");

  a_volume_write: assert property (@(posedge clk) disable iff (!rst_n)
    volume_r |-> (vol_r == $past(cfg_wdata)))
    else $error("volume register not written");
`endif

endmodule

// ===== sim/testbench.sv =====
// Testbench for the tone sequence player: directed and random requests checked by a predictor.
`timescale 1ns / 100ps

module testbench;
  import tsp_pkg::*;

  localparam int QUEUE_DEPTH = 4;
  localparam int TONE_DEPTH = 256;
  localparam int DUTY_BITS = 10;
  localparam int DUTY_TOP = (1 << DUTY_BITS) - 1;
  localparam int ON_SCALE = 1 << (DUTY_BITS - 1);
  localparam int QUIET_DIV = 4;
  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam logic [1:0] LVL_SPARE = 2'd3;
  localparam int HALF_PERIOD = 4;
  localparam int RESET_CYCLES = 10;
  localparam int PHASES = 6;
  localparam int PHASE_REQUESTS = 90;
  localparam int LONG_HOLD = 48;
  localparam int SETTLE_CYCLES = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;

  // Player state as the predictor sees it
  typedef struct packed {
    bit [TONE_DEPTH-1:0][15:0] hz;
    bit [TONE_DEPTH-1:0][15:0] ms;
    bit [TONE_DEPTH-1:0] written;
    bit [QUEUE_DEPTH-1:0][7:0] q_start;
    bit [QUEUE_DEPTH-1:0][7:0] q_len;
    bit [QUEUE_DEPTH-1:0][1:0] q_level;
    bit [1:0] q_head;
    bit [2:0] q_fill;
    bit busy;
    bit [7:0] cur_start;
    bit [7:0] cur_len;
    bit [1:0] cur_level;
    bit [7:0] step;
    bit [15:0] elapsed;
    bit [6:0] volume;
    bit active_low;
  } player_state_t;

  // What the buzzer output shows after one request
  typedef struct packed {
    logic [15:0] freq_hz;
    logic [DUTY_BITS-1:0] duty;
    logic playing;
    logic [2:0] queued;
  } tone_sound_t;

  class melody_scoreboard;
    player_state_t st;
    tone_sound_t sounds_due[$];
    int unsigned n_noted;
    int unsigned n_heard;
    int unsigned failures;

    function new();
      st = '0;
      st.volume = VOLUME_RST;
    endfunction

    // Pop the queue head into the sequencer, or go idle
    static function player_state_t next_melody(player_state_t s);
      if (s.q_fill == 0) begin
        s.busy = 1'b0;
        return s;
      end
      s.cur_start = s.q_start[s.q_head];
      s.cur_len = s.q_len[s.q_head];
      s.cur_level = s.q_level[s.q_head];
      s.q_head = s.q_head + 2'd1;
      s.q_fill = s.q_fill - 3'd1;
      s.step = '0;
      s.elapsed = '0;
      s.busy = 1'b1;
      return s;
    endfunction

    static function player_state_t apply_request(player_state_t s, tsp_item_t it);
      bit [1:0] slot;
      bit [7:0] entry;
      case (it.action)
        ACT_WRITE: begin
          s.hz[it.tone_index] = it.tone_hz;
          s.ms[it.tone_index] = it.tone_ms;
          s.written[it.tone_index] = 1'b1;
        end
        ACT_PLAY: begin
          if (it.play_count != 0) begin
            // urgent: drop the queue and the current melody first
            if (it.urgent) begin
              s.q_fill = '0;
              s.busy = 1'b0;
            end
            if (s.q_fill < QUEUE_DEPTH) begin
              slot = s.q_head + s.q_fill[1:0];
              s.q_start[slot] = it.play_start;
              s.q_len[slot] = it.play_count;
              s.q_level[slot] = it.play_level;
              s.q_fill = s.q_fill + 3'd1;
            end
            if (!s.busy) s = next_melody(s);
          end
        end
        ACT_TICK: begin
          if (s.busy) begin
            entry = s.cur_start + s.step;
            if (s.elapsed != MS_MAX) s.elapsed = s.elapsed + 16'd1;
            // advance at most one step per tick
            if (s.elapsed >= s.ms[entry]) begin
              s.step = s.step + 8'd1;
              s.elapsed = '0;
              if (s.step >= s.cur_len) s = next_melody(s);
            end
          end
        end
        default: ;
      endcase
      return s;
    endfunction

    static function tone_sound_t sound_of(player_state_t s);
      tone_sound_t r;
      bit [7:0] entry;
      int unsigned pct;
      int unsigned on;
      r.freq_hz = '0;
      r.duty = s.active_low ? DUTY_BITS'(DUTY_TOP) : '0;
      if (s.busy) begin
        entry = s.cur_start + s.step;
        case (s.cur_level)
          LVL_FULL: pct = PCT_FULL;
          LVL_QUIET: begin
            if (s.volume == 0) pct = 0;
            else if (s.volume / QUIET_DIV < PCT_QUIET_MIN) pct = PCT_QUIET_MIN;
            else pct = s.volume / QUIET_DIV;
          end
          default: pct = s.volume;
        endcase
        if (s.hz[entry] != 0 && pct != 0) begin
          on = ON_SCALE * pct / PCT_FULL;
          r.freq_hz = s.hz[entry];
          r.duty = s.active_low ? DUTY_BITS'(DUTY_TOP - on) : DUTY_BITS'(on);
        end
      end
      r.playing = s.busy;
      r.queued = s.q_fill;
      return r;
    endfunction

    function void note_request(tsp_item_t it);
      st = apply_request(st, it);
      sounds_due.push_back(sound_of(st));
      n_noted++;
    endfunction

    function void check_sound(tone_sound_t got);
      tone_sound_t want;
      n_heard++;
      if (sounds_due.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("result %0d with no request pending: freq %0d duty %0d playing %0b queued %0d",
                   n_heard, got.freq_hz, got.duty, got.playing, got.queued);
        return;
      end
      want = sounds_due.pop_front();
      if (got !== want) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("result %0d: expected freq %0d duty %0d playing %0b queued %0d, %s %0d %0d %0b %0d",
                   n_heard, want.freq_hz, want.duty, want.playing, want.queued, "got",
                   got.freq_hz, got.duty, got.playing, got.queued);
      end
    endfunction
  endclass

  bit clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic [6:0] cfg_wdata;

  tsp_in_if in_ch ();
  tsp_out_if #(.DUTY_BITS(DUTY_BITS)) out_ch ();

  tone_sequence_player #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .TONE_DEPTH(TONE_DEPTH),
    .DUTY_BITS(DUTY_BITS)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_if(in_ch),
    .out_if(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  melody_scoreboard sb = new();
  player_state_t plan;        // state after every request offered so far
  logic [7:0] last_index;
  int unsigned n_offered;
  int unsigned quiet_cycles;
  bit calm;
  bit long_hold_req;

  always #HALF_PERIOD clk = ~clk;

  // Watch both channels; count cycles in which nothing moves
  always @(posedge clk) begin
    tsp_item_t seen;
    tone_sound_t heard;
    bit req_taken;
    bit res_taken;
    req_taken = rst_n && in_ch.valid && in_ch.ready;
    res_taken = rst_n && out_ch.valid && out_ch.ready;
    if (req_taken) begin
      seen = {in_ch.action, in_ch.tone_index, in_ch.tone_hz, in_ch.tone_ms,
              in_ch.play_start, in_ch.play_count, in_ch.play_level, in_ch.urgent};
      sb.note_request(seen);
    end
    if (res_taken) begin
      heard = {out_ch.freq_hz, out_ch.duty, out_ch.playing, out_ch.queued};
      sb.check_sound(heard);
    end
    quiet_cycles <= (req_taken || res_taken) ? 0 : quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  // Result side: random stalls, one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  function automatic tsp_item_t mk_write(logic [7:0] idx, logic [15:0] hz, logic [15:0] ms);
    tsp_item_t it;
    it = '0;
    it.action = ACT_WRITE;
    it.tone_index = idx;
    it.tone_hz = hz;
    it.tone_ms = ms;
    return it;
  endfunction

  function automatic tsp_item_t mk_play(logic [7:0] start, logic [7:0] count,
                                        logic [1:0] level, logic urg);
    tsp_item_t it;
    it = '0;
    it.action = ACT_PLAY;
    it.play_start = start;
    it.play_count = count;
    it.play_level = level;
    it.urgent = urg;
    return it;
  endfunction

  function automatic tsp_item_t mk_other(logic [1:0] act);
    tsp_item_t it;
    it = '0;
    it.action = act;
    return it;
  endfunction

  function automatic logic [15:0] rand_hz();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 20) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  // Mostly short tones so melodies move; now and then a very long one
  function automatic logic [15:0] rand_ms();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 16'($urandom_range(0, 3));
    if (r < 85) return 16'($urandom_range(4, 12));
    if (r < 95) return 16'($urandom_range(13, 300));
    return 16'($urandom);
  endfunction

  function automatic tsp_item_t random_request();
    tsp_item_t it;
    logic [63:0] noise;
    logic [7:0] pick;
    int unsigned r;
    int unsigned c;
    // unused fields carry random bits
    noise = {$urandom, $urandom};
    it = noise[$bits(tsp_item_t)-1:0];
    r = $urandom_range(0, 99);
    if (r < 4) begin
      it.action = ACT_NONE;
    end else if (r < 30) begin
      it.action = ACT_WRITE;
      it.tone_index = $urandom_range(0, 1) ? last_index + 8'd1 : 8'($urandom);
      it.tone_hz = rand_hz();
      it.tone_ms = rand_ms();
    end else if (r < 50) begin
      it.action = ACT_PLAY;
      pick = 8'($urandom);
      for (int k = 0; k < 16 && !plan.written[pick]; k++) pick = 8'($urandom);
      it.play_start = pick;
      c = $urandom_range(0, 99);
      if (c < 8) it.play_count = '0;
      else if (c < 18) it.play_count = 8'($urandom_range(1, 255));
      else it.play_count = 8'($urandom_range(1, 6));
      it.play_level = ($urandom_range(0, 9) == 0) ? LVL_SPARE : 2'($urandom_range(0, 2));
      it.urgent = ($urandom_range(0, 7) == 0);
    end else begin
      it.action = ACT_TICK;
    end
    return it;
  endfunction

  // Offer one request; swap in a tone write where it would sound an unwritten entry
  task automatic send(tsp_item_t it);
    player_state_t trial;
    logic [7:0] entry;
    trial = melody_scoreboard::apply_request(plan, it);
    entry = trial.cur_start + trial.step;
    if (trial.busy && !trial.written[entry]) it = mk_write(entry, rand_hz(), rand_ms());
    plan = melody_scoreboard::apply_request(plan, it);
    if (it.action == ACT_WRITE) last_index = it.tone_index;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= it.action;
    in_ch.tone_index <= it.tone_index;
    in_ch.tone_hz <= it.tone_hz;
    in_ch.tone_ms <= it.tone_ms;
    in_ch.play_start <= it.play_start;
    in_ch.play_count <= it.play_count;
    in_ch.play_level <= it.play_level;
    in_ch.urgent <= it.urgent;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    n_offered++;
  endtask

  // Hold the input and wait until every result is back
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.n_noted != n_offered || sb.sounds_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(logic [6:0] vol, logic al);
    cfg_we <= 1'b1;
    cfg_index <= CFG_VOLUME;
    cfg_wdata <= vol;
    @(posedge clk);
    cfg_index <= CFG_ACTIVE_LOW;
    cfg_wdata <= {6'd0, al};
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    sb.st.volume = vol;
    sb.st.active_low = al;
    plan.volume = vol;
    plan.active_low = al;
  endtask

  initial begin
    logic [6:0] vol_list[PHASES];
    logic al_list[PHASES];
    vol_list = '{7'd0, 7'd127, 7'd11, 7'd1, 7'd0, 7'd100};
    al_list = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
    plan = '0;
    plan.volume = VOLUME_RST;
    last_index = '0;
    n_offered = 0;
    quiet_cycles = 0;
    calm = 1'b0;
    long_hold_req = 1'b0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_VOLUME;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.action <= ACT_WRITE;
    in_ch.tone_index <= '0;
    in_ch.tone_hz <= '0;
    in_ch.tone_ms <= '0;
    in_ch.play_start <= '0;
    in_ch.play_count <= '0;
    in_ch.play_level <= LVL_NORMAL;
    in_ch.urgent <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: idle tick, unused code, wrap-around melody, ignored and dropped plays
    send(mk_other(ACT_TICK));
    send(mk_other(ACT_NONE));
    send(mk_write(8'd0, 16'hFFFF, 16'd0));
    send(mk_write(8'd255, 16'd0, 16'd1));
    send(mk_write(8'd1, 16'd440, 16'd2));
    send(mk_write(8'd2, 16'd1, 16'hFFFF));
    send(mk_play(8'd255, 8'd0, LVL_NORMAL, 1'b0));
    send(mk_play(8'd255, 8'd3, LVL_QUIET, 1'b0));
    send(mk_play(8'd0, 8'd255, LVL_FULL, 1'b0));
    send(mk_play(8'd1, 8'd1, LVL_SPARE, 1'b0));
    send(mk_play(8'd2, 8'd2, LVL_NORMAL, 1'b0));
    send(mk_play(8'd0, 8'd1, LVL_FULL, 1'b0));
    send(mk_play(8'd1, 8'd1, LVL_QUIET, 1'b0));
    repeat (8) send(mk_other(ACT_TICK));
    send(mk_play(8'd1, 8'd1, LVL_QUIET, 1'b1));
    repeat (2) send(mk_other(ACT_TICK));
    drain();

    // Random phases, each under its own register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 4) set_config(7'($urandom_range(0, 127)), 1'($urandom));
      else set_config(vol_list[ph], al_list[ph]);
      calm = (ph == PHASES - 1);
      if (ph == 1) long_hold_req = 1'b1;
      for (int n = 0; n < PHASE_REQUESTS; n++) send(random_request());
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.sounds_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== tone_sequence_player.f =====
hw/rtl/tsp_pkg.sv
hw/rtl/tsp_in_if.sv
hw/rtl/tsp_out_if.sv
hw/rtl/tsp_tone_mem.sv
hw/rtl/tsp_ctrl.sv
hw/rtl/tsp_duty.sv
hw/rtl/tone_sequence_player.sv
sim/testbench.sv
